[hw/rtl/gtr_pkg.sv]
// Shared types and constants for the gravity tangent retraction block.
// No dependencies; every other file of the block imports this package.
package gtr_pkg;

   localparam int unsigned BASIS_FRAC = 30;
   localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;

   typedef enum logic {
      OP_PLUS  = 1'b0,
      OP_MINUS = 1'b1
   } op_type;

   typedef struct packed {
      op_type             operation;
      logic signed [31:0] gravity_x;
      logic signed [31:0] gravity_y;
      logic signed [31:0] gravity_z;
      logic signed [31:0] delta_u;
      logic signed [31:0] delta_v;
      logic signed [31:0] target_x;
      logic signed [31:0] target_y;
      logic signed [31:0] target_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic signed [31:0] basis_b_x;
      logic signed [31:0] basis_b_y;
      logic signed [31:0] basis_b_z;
      logic signed [31:0] basis_c_x;
      logic signed [31:0] basis_c_y;
      logic signed [31:0] basis_c_z;
      logic               degenerate;
   } rsp_type;

endpackage

[hw/rtl/gtr_unit3.sv]
// Pipelined 3-vector normalizer: magnitude, shift, squares, digit-serial
// square root stages and restoring divide stages. Uses gtr_pkg.
module gtr_unit3 #(
   parameter int unsigned SIDE_W = 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [2:0][32:0]  in_vec,
   input  logic [SIDE_W-1:0] in_side,
   output logic              out_valid,
   output logic [2:0][31:0]  out_vec,
   output logic              out_zero,
   output logic [SIDE_W-1:0] out_side
);
   import gtr_pkg::*;

   localparam int unsigned SQ_STEPS  = 32;
   localparam int unsigned DIV_STEPS = 31;
   localparam int unsigned MW        = SIDE_W + 100;
   localparam int unsigned DW        = SIDE_W + 4;

   // stage 1: magnitudes
   logic              v1_ff;
   logic [2:0][31:0]  mag1_ff, mag1_in;
   logic [2:0]        neg1_ff, neg1_in;
   logic [SIDE_W-1:0] side1_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         neg1_in[i] = in_vec[i][32];
         mag1_in[i] = in_vec[i][32] ? 32'(~in_vec[i] + 33'd1) : in_vec[i][31:0];
      end
   end

   // stage 2: align largest magnitude to bit 30
   logic             v2_ff;
   logic [MW-1:0]    m2_ff, m2_in;
   logic [31:0]      mx;
   logic [4:0]       msb;
   logic [4:0]       sh;
   logic [2:0][31:0] mag2;

   always_comb begin
      mx = mag1_ff[0];
      if (mag1_ff[1] > mx) mx = mag1_ff[1];
      if (mag1_ff[2] > mx) mx = mag1_ff[2];
      msb = '0;
      for (int k = 0; k < 32; k++) begin
         if (mx[k]) msb = 5'(k);
      end
      sh = (msb >= 5'd30) ? 5'd0 : 5'd30 - msb;
      for (int i = 0; i < 3; i++) mag2[i] = mag1_ff[i] << sh;
      m2_in = {side1_ff, neg1_ff, (mx == 32'd0), mag2};
   end

   // stage 3: squares
   logic             v3_ff;
   logic [MW-1:0]    m3_ff;
   logic [2:0][63:0] sq3_ff, sq3_in;

   always_comb begin
      for (int i = 0; i < 3; i++) sq3_in[i] = 64'(m2_ff[32*i +: 32]) * 64'(m2_ff[32*i +: 32]);
   end

   // square root, one result bit per stage
   logic [63:0]   sqx_ff [SQ_STEPS+1];
   logic [63:0]   sqr_ff [SQ_STEPS+1];
   logic [MW-1:0] sqm_ff [SQ_STEPS+1];
   logic          sqv_ff [SQ_STEPS+1];
   logic [63:0]   sqx_in [SQ_STEPS];
   logic [63:0]   sqr_in [SQ_STEPS];

   always_comb begin
      logic [63:0] bitv;
      logic [64:0] trial;
      for (int k = 0; k < SQ_STEPS; k++) begin
         bitv  = 64'd1 << (62 - 2 * k);
         trial = {1'b0, sqr_ff[k]} + {1'b0, bitv};
         if ({1'b0, sqx_ff[k]} >= trial) begin
            sqx_in[k] = sqx_ff[k] - trial[63:0];
            sqr_in[k] = (sqr_ff[k] >> 1) + bitv;
         end else begin
            sqx_in[k] = sqx_ff[k];
            sqr_in[k] = sqr_ff[k] >> 1;
         end
      end
   end

   // restoring divide, one quotient bit per stage
   logic [2:0][62:0] dr_ff [DIV_STEPS+1];
   logic [2:0][30:0] dq_ff [DIV_STEPS+1];
   logic [31:0]      dn_ff [DIV_STEPS+1];
   logic [DW-1:0]    dm_ff [DIV_STEPS+1];
   logic             dv_ff [DIV_STEPS+1];
   logic [2:0][62:0] dr_in [DIV_STEPS];
   logic [2:0][30:0] dq_in [DIV_STEPS];
   logic [2:0][62:0] dr0_in;
   logic [31:0]      n_root;

   assign n_root = sqr_ff[SQ_STEPS][31:0];

   always_comb begin
      logic [62:0] dsr;
      for (int i = 0; i < 3; i++) begin
         dr0_in[i] = (63'(sqm_ff[SQ_STEPS][32*i +: 32]) << BASIS_FRAC) + 63'(n_root >> 1);
      end
      for (int j = 0; j < DIV_STEPS; j++) begin
         dsr = 63'(dn_ff[j]) << (DIV_STEPS - 1 - j);
         for (int i = 0; i < 3; i++) begin
            dr_in[j][i] = dr_ff[j][i];
            dq_in[j][i] = dq_ff[j][i];
            if (dr_ff[j][i] >= dsr) begin
               dr_in[j][i] = dr_ff[j][i] - dsr;
               dq_in[j][i][DIV_STEPS - 1 - j] = 1'b1;
            end
         end
      end
   end

   // final sign stage
   logic              vo_ff;
   logic [2:0][31:0]  out_ff, out_in;
   logic              zero_ff;
   logic [SIDE_W-1:0] side_ff;
   logic [DW-1:0]     dlast;

   assign dlast = dm_ff[DIV_STEPS];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (dlast[0]) begin
            out_in[i] = '0;
         end else if (dlast[1 + i]) begin
            out_in[i] = 32'(~{1'b0, dq_ff[DIV_STEPS][i]} + 32'd1);
         end else begin
            out_in[i] = {1'b0, dq_ff[DIV_STEPS][i]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         vo_ff <= 1'b0;
         for (int k = 0; k <= SQ_STEPS; k++) sqv_ff[k] <= 1'b0;
         for (int j = 0; j <= DIV_STEPS; j++) dv_ff[j] <= 1'b0;
      end else if (en) begin
         v1_ff     <= in_valid;
         v2_ff     <= v1_ff;
         v3_ff     <= v2_ff;
         sqv_ff[0] <= v3_ff;
         for (int k = 0; k < SQ_STEPS; k++) sqv_ff[k+1] <= sqv_ff[k];
         dv_ff[0] <= sqv_ff[SQ_STEPS];
         for (int j = 0; j < DIV_STEPS; j++) dv_ff[j+1] <= dv_ff[j];
         vo_ff <= dv_ff[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag1_ff  <= mag1_in;
         neg1_ff  <= neg1_in;
         side1_ff <= in_side;
         m2_ff    <= m2_in;
         m3_ff    <= m2_ff;
         sq3_ff   <= sq3_in;
         sqx_ff[0] <= sq3_ff[0] + sq3_ff[1] + sq3_ff[2];
         sqr_ff[0] <= '0;
         sqm_ff[0] <= m3_ff;
         for (int k = 0; k < SQ_STEPS; k++) begin
            sqx_ff[k+1] <= sqx_in[k];
            sqr_ff[k+1] <= sqr_in[k];
            sqm_ff[k+1] <= sqm_ff[k];
         end
         dr_ff[0] <= dr0_in;
         dq_ff[0] <= '0;
         dn_ff[0] <= n_root;
         dm_ff[0] <= {sqm_ff[SQ_STEPS][MW-1:100], sqm_ff[SQ_STEPS][99:97],
                      sqm_ff[SQ_STEPS][96]};
         for (int j = 0; j < DIV_STEPS; j++) begin
            dr_ff[j+1] <= dr_in[j];
            dq_ff[j+1] <= dq_in[j];
            dn_ff[j+1] <= dn_ff[j];
            dm_ff[j+1] <= dm_ff[j];
         end
         out_ff  <= out_in;
         zero_ff <= dlast[0];
         side_ff <= dlast[DW-1:4];
      end
   end

   assign out_valid = vo_ff;
   assign out_vec   = out_ff;
   assign out_zero  = zero_ff;
   assign out_side  = side_ff;

endmodule

[hw/rtl/gravity_tangent_retraction.sv]
// Gravity tangent retraction: basis build plus retract/lift, fully pipelined.
// One req beat is accepted per cycle while rsp is not stalled.
// Depth is set by the two normalizers (32 root stages, 31 divide stages each).
// A stalled rsp freezes the whole pipeline; req_stall follows it.
// Synchronous reset clears all valid bits; payload registers are not reset.
module gravity_tangent_retraction (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  gtr_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output gtr_pkg::rsp_type rsp_data
);
   import gtr_pkg::*;

   typedef struct packed {
      req_type          req;
      logic [2:0][31:0] a;
      logic             degen;
   } mid_type;

   localparam int unsigned REQ_W = $bits(req_type);
   localparam int unsigned MID_W = $bits(mid_type);

   logic en;
   logic rsp_valid_ff;

   assign en        = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !en;

   // first normalizer: a = g / |g|
   logic [2:0][32:0]  g_vec;
   logic              u1_valid;
   logic [2:0][31:0]  u1_vec;
   logic              u1_zero;
   logic [REQ_W-1:0]  u1_side;

   assign g_vec[0] = {req_data.gravity_x[31], req_data.gravity_x};
   assign g_vec[1] = {req_data.gravity_y[31], req_data.gravity_y};
   assign g_vec[2] = {req_data.gravity_z[31], req_data.gravity_z};

   gtr_unit3 #(.SIDE_W(REQ_W)) u_norm_a (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(req_valid), .in_vec(g_vec), .in_side(req_data),
      .out_valid(u1_valid), .out_vec(u1_vec), .out_zero(u1_zero), .out_side(u1_side)
   );

   // project reference axis
   logic              a1_v_ff;
   logic [2:0][63:0]  a1_p_ff, a1_p_in;
   logic              a1_x_ff, a1_x_in;
   mid_type           a1_mid_ff, a1_mid_in;
   logic [31:0]       dot;

   always_comb begin
      a1_x_in = (u1_vec[0] == '0) && (u1_vec[1] == '0) && (u1_vec[2] == ONE_Q30);
      dot     = a1_x_in ? u1_vec[0] : u1_vec[2];
      for (int i = 0; i < 3; i++) a1_p_in[i] = 64'($signed(u1_vec[i]) * $signed(dot));
      a1_mid_in.req   = req_type'(u1_side);
      a1_mid_in.a     = u1_vec;
      a1_mid_in.degen = u1_zero;
   end

   logic [2:0][32:0] tmp_vec;

   always_comb begin
      logic signed [63:0] pr;
      logic signed [63:0] rq;
      logic signed [32:0] ax;
      for (int i = 0; i < 3; i++) begin
         pr = $signed(a1_p_ff[i]) + 64'sd536870912;
         rq = pr >>> BASIS_FRAC;
         if (a1_x_ff) ax = (i == 0) ? 33'sd1073741824 : 33'sd0;
         else ax = (i == 2) ? 33'sd1073741824 : 33'sd0;
         tmp_vec[i] = ax - rq[32:0];
      end
   end

   // second normalizer: b
   logic              u2_valid;
   logic [2:0][31:0]  u2_vec;
   logic              u2_zero;
   logic [MID_W-1:0]  u2_side;

   gtr_unit3 #(.SIDE_W(MID_W)) u_norm_b (
      .clock(clock), .reset(reset), .en(en),
      .in_valid(a1_v_ff), .in_vec(tmp_vec), .in_side(a1_mid_ff),
      .out_valid(u2_valid), .out_vec(u2_vec), .out_zero(u2_zero), .out_side(u2_side)
   );

   // cross product partials
   logic             c1_v_ff;
   logic [5:0][63:0] c1_p_ff, c1_p_in;
   logic [2:0][31:0] c1_b_ff;
   mid_type          c1_mid_ff, c1_mid_in, u2_mid;

   always_comb begin
      u2_mid = mid_type'(u2_side);
      c1_p_in[0] = 64'($signed(u2_mid.a[1]) * $signed(u2_vec[2]));
      c1_p_in[1] = 64'($signed(u2_mid.a[2]) * $signed(u2_vec[1]));
      c1_p_in[2] = 64'($signed(u2_mid.a[2]) * $signed(u2_vec[0]));
      c1_p_in[3] = 64'($signed(u2_mid.a[0]) * $signed(u2_vec[2]));
      c1_p_in[4] = 64'($signed(u2_mid.a[0]) * $signed(u2_vec[1]));
      c1_p_in[5] = 64'($signed(u2_mid.a[1]) * $signed(u2_vec[0]));
      c1_mid_in       = u2_mid;
      c1_mid_in.degen = u2_mid.degen | u2_zero;
   end

   // c = a x b, rounded and clamped
   logic             c2_v_ff;
   logic [2:0][31:0] c2_c_ff, c2_c_in;
   logic [2:0][31:0] c2_b_ff;
   mid_type          c2_mid_ff;

   always_comb begin
      logic signed [64:0] d;
      logic signed [34:0] r;
      for (int i = 0; i < 3; i++) begin
         d = 65'($signed(c1_p_ff[2*i])) - 65'($signed(c1_p_ff[2*i+1])) + 65'sd536870912;
         r = 35'(d >>> BASIS_FRAC);
         if (r > 35'sd1073741824) c2_c_in[i] = ONE_Q30;
         else if (r < -35'sd1073741824) c2_c_in[i] = -ONE_Q30;
         else c2_c_in[i] = r[31:0];
      end
   end

   // output products
   logic             m1_v_ff;
   logic [5:0][64:0] m1_p_ff, m1_p_in;
   logic [2:0][31:0] m1_b_ff, m1_c_ff;
   mid_type          m1_mid_ff;

   always_comb begin
      logic signed [32:0] gv [3];
      logic signed [32:0] tv [3];
      logic signed [32:0] y1;
      logic signed [32:0] y2;
      gv[0] = 33'(c2_mid_ff.req.gravity_x);
      gv[1] = 33'(c2_mid_ff.req.gravity_y);
      gv[2] = 33'(c2_mid_ff.req.gravity_z);
      tv[0] = 33'(c2_mid_ff.req.target_x) - gv[0];
      tv[1] = 33'(c2_mid_ff.req.target_y) - gv[1];
      tv[2] = 33'(c2_mid_ff.req.target_z) - gv[2];
      for (int i = 0; i < 3; i++) begin
         if (c2_mid_ff.req.operation == OP_MINUS) begin
            y1 = tv[i];
            y2 = tv[i];
         end else begin
            y1 = 33'(c2_mid_ff.req.delta_u);
            y2 = 33'(c2_mid_ff.req.delta_v);
         end
         m1_p_in[i]     = 65'($signed(c2_b_ff[i]) * y1);
         m1_p_in[i + 3] = 65'($signed(c2_c_ff[i]) * y2);
      end
   end

   // accumulate, round, saturate
   rsp_type rsp_ff, rsp_in;

   always_comb begin
      logic signed [67:0] s [3];
      logic signed [67:0] gs;
      logic signed [37:0] r;
      logic [2:0][31:0]   o;
      logic signed [31:0] gsrc [3];
      gs = '0;
      gsrc[0] = m1_mid_ff.req.gravity_x;
      gsrc[1] = m1_mid_ff.req.gravity_y;
      gsrc[2] = m1_mid_ff.req.gravity_z;
      if (m1_mid_ff.req.operation == OP_MINUS) begin
         s[0] = 68'($signed(m1_p_ff[0])) + 68'($signed(m1_p_ff[1])) + 68'($signed(m1_p_ff[2]));
         s[1] = 68'($signed(m1_p_ff[3])) + 68'($signed(m1_p_ff[4])) + 68'($signed(m1_p_ff[5]));
         s[2] = '0;
      end else begin
         for (int i = 0; i < 3; i++) begin
            gs   = 68'(gsrc[i]) <<< BASIS_FRAC;
            s[i] = gs + 68'($signed(m1_p_ff[i])) + 68'($signed(m1_p_ff[i + 3]));
         end
      end
      for (int i = 0; i < 3; i++) begin
         r = 38'((s[i] + 68'sd536870912) >>> BASIS_FRAC);
         if (r > 38'sd2147483647) o[i] = 32'h7fff_ffff;
         else if (r < -38'sd2147483648) o[i] = 32'h8000_0000;
         else o[i] = r[31:0];
      end
      if (m1_mid_ff.req.operation == OP_MINUS) o[2] = '0;
      rsp_in.out_x      = o[0];
      rsp_in.out_y      = o[1];
      rsp_in.out_z      = o[2];
      rsp_in.basis_b_x  = m1_b_ff[0];
      rsp_in.basis_b_y  = m1_b_ff[1];
      rsp_in.basis_b_z  = m1_b_ff[2];
      rsp_in.basis_c_x  = m1_c_ff[0];
      rsp_in.basis_c_y  = m1_c_ff[1];
      rsp_in.basis_c_z  = m1_c_ff[2];
      rsp_in.degenerate = m1_mid_ff.degen;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a1_v_ff      <= 1'b0;
         c1_v_ff      <= 1'b0;
         c2_v_ff      <= 1'b0;
         m1_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         a1_v_ff      <= u1_valid;
         c1_v_ff      <= u2_valid;
         c2_v_ff      <= c1_v_ff;
         m1_v_ff      <= c2_v_ff;
         rsp_valid_ff <= m1_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a1_p_ff   <= a1_p_in;
         a1_x_ff   <= a1_x_in;
         a1_mid_ff <= a1_mid_in;
         c1_p_ff   <= c1_p_in;
         c1_b_ff   <= u2_vec;
         c1_mid_ff <= c1_mid_in;
         c2_c_ff   <= c2_c_in;
         c2_b_ff   <= c1_b_ff;
         c2_mid_ff <= c1_mid_ff;
         m1_p_ff   <= m1_p_in;
         m1_b_ff   <= c2_b_ff;
         m1_c_ff   <= c2_c_ff;
         m1_mid_ff <= c2_mid_ff;
         rsp_ff    <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

[hw/rtl/gtr_checker.sv]
// Port-level checks for the gravity tangent retraction block, bound to the top.
// Depends on gtr_pkg for the beat types.
module gtr_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input gtr_pkg::rsp_type rsp_data
);
   import gtr_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("rsp beat changed while stalled");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("req stalled without rsp backpressure");

   a_reset_clear: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid after reset");

   a_c_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.basis_c_x <= ONE_Q30 && rsp_data.basis_c_x >= -ONE_Q30
         && rsp_data.basis_c_y <= ONE_Q30 && rsp_data.basis_c_y >= -ONE_Q30
         && rsp_data.basis_c_z <= ONE_Q30 && rsp_data.basis_c_z >= -ONE_Q30)
      else $error("basis c out of unit range");

   a_b_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.degenerate |->
         rsp_data.basis_b_x != 0 || rsp_data.basis_b_y != 0 || rsp_data.basis_b_z != 0)
      else $error("zero basis b without degenerate flag");

endmodule

bind gravity_tangent_retraction gtr_checker u_gtr_checker (.*);
